// ----- rtl/hrhp_pkg.sv -----
// ---------------------------------------------------------------------------
// hrhp_pkg
// Shared widths, byte class codes, line event codes and character constants
// for the HTTP response header parser.
// ---------------------------------------------------------------------------
package hrhp_pkg;

  localparam int ByteW   = 8;
  localparam int KindW   = 3;
  localparam int EventW  = 2;
  localparam int StatusW = 10;
  localparam int StateW  = 5;

  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [KindW-1:0]   kind_t;
  typedef logic [EventW-1:0]  event_t;
  typedef logic [StatusW-1:0] status_t;

  // byte classes
  localparam kind_t K_FRAME  = 3'd0;
  localparam kind_t K_REASON = 3'd1;
  localparam kind_t K_NAME   = 3'd2;
  localparam kind_t K_VALUE  = 3'd3;
  localparam kind_t K_BODY   = 3'd4;
  localparam kind_t K_ERROR  = 3'd5;

  // line events
  localparam event_t LE_NONE   = 2'd0;
  localparam event_t LE_STATUS = 2'd1;
  localparam event_t LE_HEADER = 2'd2;
  localparam event_t LE_BLOCK  = 2'd3;

  // characters
  localparam byte_t CH_H     = 8'h48;
  localparam byte_t CH_T     = 8'h54;
  localparam byte_t CH_P     = 8'h50;
  localparam byte_t CH_SLASH = 8'h2f;
  localparam byte_t CH_DOT   = 8'h2e;
  localparam byte_t CH_COLON = 8'h3a;
  localparam byte_t CH_SP    = 8'h20;
  localparam byte_t CH_HT    = 8'h09;
  localparam byte_t CH_CR    = 8'h0d;
  localparam byte_t CH_LF    = 8'h0a;
  localparam byte_t CH_ZERO  = 8'h30;
  localparam byte_t CH_NINE  = 8'h39;
  localparam byte_t CH_DEL   = 8'h7f;
  localparam byte_t CTL_MAX  = 8'h1f;

  localparam byte_t VER_MAX  = 8'hff;

endpackage

// ----- rtl/hrhp_if.sv -----
// ---------------------------------------------------------------------------
// hrhp_byte_if / hrhp_result_if
// Valid/ready channels for received bytes and for classified results.
// ---------------------------------------------------------------------------
interface hrhp_byte_if import hrhp_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  first_byte;
  byte_t byte_value;

  modport source (output valid, output first_byte, output byte_value, input ready);
  modport sink   (input valid, input first_byte, input byte_value, output ready);
endinterface

interface hrhp_result_if import hrhp_pkg::*; ();
  logic    valid;
  logic    ready;
  byte_t   byte_out;
  kind_t   byte_kind;
  logic    name_start;
  logic    value_start;
  event_t  line_event;
  byte_t   version_major;
  byte_t   version_minor;
  status_t status_code;

  modport source (output valid, output byte_out, output byte_kind, output name_start,
                  output value_start, output line_event, output version_major,
                  output version_minor, output status_code, input ready);
  modport sink   (input valid, input byte_out, input byte_kind, input name_start,
                  input value_start, input line_event, input version_major,
                  input version_minor, input status_code, output ready);
endinterface

// ----- rtl/http_response_header_parser.sv -----
// ---------------------------------------------------------------------------
// http_response_header_parser
// Byte-at-a-time HTTP/1.x status line and header block classifier.
// ---------------------------------------------------------------------------
// One byte enters per clock unless the result channel stalls, and its result
// leaves from the output register on the next cycle; the grammar step and
// the decimal accumulate sit in the single combinational path from the byte
// channel into the parse registers and the result register. The byte channel
// is ready whenever the result register is empty or being taken. A byte with
// first_byte set restarts the parse; after a grammar error every byte is
// reported as an error until such a restart.
module http_response_header_parser import hrhp_pkg::*; (
  input logic              clk,
  input logic              rst,
  hrhp_byte_if.sink        byte_ch,
  hrhp_result_if.source    result_ch
);

  localparam logic [StateW-1:0] S_H      = 5'd0;
  localparam logic [StateW-1:0] S_T1     = 5'd1;
  localparam logic [StateW-1:0] S_T2     = 5'd2;
  localparam logic [StateW-1:0] S_P      = 5'd3;
  localparam logic [StateW-1:0] S_SLASH  = 5'd4;
  localparam logic [StateW-1:0] S_MAJ0   = 5'd5;
  localparam logic [StateW-1:0] S_MAJ    = 5'd6;
  localparam logic [StateW-1:0] S_MIN0   = 5'd7;
  localparam logic [StateW-1:0] S_MIN    = 5'd8;
  localparam logic [StateW-1:0] S_ST1    = 5'd9;
  localparam logic [StateW-1:0] S_ST2    = 5'd10;
  localparam logic [StateW-1:0] S_ST3    = 5'd11;
  localparam logic [StateW-1:0] S_STSP   = 5'd12;
  localparam logic [StateW-1:0] S_REASON = 5'd13;
  localparam logic [StateW-1:0] S_SLLF   = 5'd14;
  localparam logic [StateW-1:0] S_LINE   = 5'd15;
  localparam logic [StateW-1:0] S_NAME   = 5'd16;
  localparam logic [StateW-1:0] S_VWS    = 5'd17;
  localparam logic [StateW-1:0] S_VAL    = 5'd18;
  localparam logic [StateW-1:0] S_HLLF   = 5'd19;
  localparam logic [StateW-1:0] S_ENDLF  = 5'd20;
  localparam logic [StateW-1:0] S_BODY   = 5'd21;

  function automatic logic is_digit(byte_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_ctl(byte_t c);
    return (c <= CTL_MAX) || (c == CH_DEL);
  endfunction

  function automatic logic is_ws(byte_t c);
    return (c == CH_SP) || (c == CH_HT);
  endfunction

  function automatic logic is_sep(byte_t c);
    logic r;
    case (c) inside
      8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h5c, 8'h22,
      8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d, 8'h20, 8'h09: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_tok(byte_t c);
    return !is_ctl(c) && !is_sep(c);
  endfunction

  function automatic logic is_text(byte_t c);
    return is_ws(c) || !is_ctl(c);
  endfunction

  // acc * 10 + digit, saturating at 255
  function automatic byte_t sat_dec(byte_t acc, byte_t c);
    logic [11:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {4'h0, c - CH_ZERO};
    return (v > {4'h0, VER_MAX}) ? VER_MAX : v[7:0];
  endfunction

  logic [StateW-1:0] state, state_next;
  byte_t             major_acc, major_next;
  byte_t             minor_acc, minor_next;
  status_t           status_acc, status_next;
  logic              failed, failed_next;

  logic              take;
  logic              out_valid;
  byte_t             c;
  logic [StateW-1:0] st_cur;
  byte_t             maj_cur, min_cur;
  status_t           sts_cur;
  logic              fail_cur;
  logic [StateW-1:0] s;
  byte_t             maj_s, min_s;
  status_t           sts_s;
  logic [13:0]       sts_wide;
  logic              ok;
  kind_t             kind, kind_next;
  logic              ns, vs;
  event_t            ev, ev_next;
  status_t           status_out;

  assign byte_ch.ready = !out_valid || result_ch.ready;
  assign take          = byte_ch.valid && byte_ch.ready;
  assign c             = byte_ch.byte_value;

  always_comb begin
    // restart wipes the parse before this byte is taken
    st_cur   = byte_ch.first_byte ? S_H : state;
    maj_cur  = byte_ch.first_byte ? '0 : major_acc;
    min_cur  = byte_ch.first_byte ? '0 : minor_acc;
    sts_cur  = byte_ch.first_byte ? '0 : status_acc;
    fail_cur = byte_ch.first_byte ? 1'b0 : failed;

    s        = st_cur;
    maj_s    = maj_cur;
    min_s    = min_cur;
    sts_s    = sts_cur;
    sts_wide = {1'b0, sts_cur, 3'b000} + {3'b000, sts_cur, 1'b0} + {6'd0, c - CH_ZERO};
    ok       = 1'b1;
    kind     = K_FRAME;
    ns       = 1'b0;
    vs       = 1'b0;
    ev       = LE_NONE;

    unique case (st_cur)
      S_H: begin
        maj_s = '0;
        min_s = '0;
        sts_s = '0;
        if (c == CH_H) s = S_T1; else ok = 1'b0;
      end
      S_T1:    if (c == CH_T) s = S_T2; else ok = 1'b0;
      S_T2:    if (c == CH_T) s = S_P; else ok = 1'b0;
      S_P:     if (c == CH_P) s = S_SLASH; else ok = 1'b0;
      S_SLASH: if (c == CH_SLASH) s = S_MAJ0; else ok = 1'b0;
      S_MAJ0: begin
        if (is_digit(c)) begin
          maj_s = sat_dec(maj_cur, c);
          s     = S_MAJ;
        end else ok = 1'b0;
      end
      S_MAJ: begin
        if (is_digit(c)) maj_s = sat_dec(maj_cur, c);
        else if (c == CH_DOT) s = S_MIN0;
        else ok = 1'b0;
      end
      S_MIN0: begin
        if (is_digit(c)) begin
          min_s = sat_dec(min_cur, c);
          s     = S_MIN;
        end else ok = 1'b0;
      end
      S_MIN: begin
        if (is_digit(c)) min_s = sat_dec(min_cur, c);
        else if (c == CH_SP) s = S_ST1;
        else ok = 1'b0;
      end
      S_ST1, S_ST2, S_ST3: begin
        if (is_digit(c)) begin
          sts_s = sts_wide[StatusW-1:0];
          s     = st_cur + 5'd1;
        end else ok = 1'b0;
      end
      S_STSP: if (c == CH_SP) s = S_REASON; else ok = 1'b0;
      S_REASON: begin
        if (c == CH_CR) s = S_SLLF;
        else if (is_text(c)) kind = K_REASON;
        else ok = 1'b0;
      end
      S_SLLF: begin
        if (c == CH_LF) begin
          s  = S_LINE;
          ev = LE_STATUS;
        end else ok = 1'b0;
      end
      S_LINE: begin
        if (c == CH_CR) s = S_ENDLF;
        else if (is_tok(c)) begin
          kind = K_NAME;
          ns   = 1'b1;
          s    = S_NAME;
        end else ok = 1'b0;
      end
      S_NAME: begin
        if (c == CH_COLON) s = S_VWS;
        else if (is_tok(c)) kind = K_NAME;
        else ok = 1'b0;
      end
      S_VWS: begin
        // skip leading whitespace before the value
        if (c == CH_CR) s = S_HLLF;
        else if (is_ws(c)) s = S_VWS;
        else if (!is_ctl(c)) begin
          kind = K_VALUE;
          vs   = 1'b1;
          s    = S_VAL;
        end else ok = 1'b0;
      end
      S_VAL: begin
        if (c == CH_CR) s = S_HLLF;
        else if (is_text(c)) kind = K_VALUE;
        else ok = 1'b0;
      end
      S_HLLF: begin
        if (c == CH_LF) begin
          s  = S_LINE;
          ev = LE_HEADER;
        end else ok = 1'b0;
      end
      S_ENDLF: begin
        if (c == CH_LF) begin
          s  = S_BODY;
          ev = LE_BLOCK;
        end else ok = 1'b0;
      end
      S_BODY:  kind = K_BODY;
      default: ok = 1'b0;
    endcase

    if (fail_cur) begin
      // sticky error: hold everything
      state_next  = st_cur;
      major_next  = maj_cur;
      minor_next  = min_cur;
      status_next = sts_cur;
      failed_next = 1'b1;
      kind_next   = K_ERROR;
      ev_next     = LE_NONE;
      ns          = 1'b0;
      vs          = 1'b0;
    end else if (!ok) begin
      state_next  = st_cur;
      major_next  = maj_cur;
      minor_next  = min_cur;
      status_next = sts_cur;
      failed_next = 1'b1;
      kind_next   = K_ERROR;
      ev_next     = LE_NONE;
      ns          = 1'b0;
      vs          = 1'b0;
    end else begin
      state_next  = s;
      major_next  = maj_s;
      minor_next  = min_s;
      status_next = sts_s;
      failed_next = 1'b0;
      kind_next   = kind;
      ev_next     = ev;
    end

    status_out = (state_next >= S_REASON && state_next <= S_BODY) ? status_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_H;
      major_acc  <= '0;
      minor_acc  <= '0;
      status_acc <= '0;
      failed     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        state      <= state_next;
        major_acc  <= major_next;
        minor_acc  <= minor_next;
        status_acc <= status_next;
        failed     <= failed_next;
        out_valid  <= 1'b1;
      end else if (result_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload: load on every byte transfer
  always_ff @(posedge clk) begin
    if (take) begin
      result_ch.byte_out      <= c;
      result_ch.byte_kind     <= kind_next;
      result_ch.name_start    <= ns;
      result_ch.value_start   <= vs;
      result_ch.line_event    <= ev_next;
      result_ch.version_major <= major_next;
      result_ch.version_minor <= minor_next;
      result_ch.status_code   <= status_out;
    end
  end

  assign result_ch.valid = out_valid;

  a_sticky_error: assert property (@(posedge clk) disable iff (rst)
    take && failed && !byte_ch.first_byte |=> result_ch.byte_kind == K_ERROR)
    else $error("error not held until restart");

  a_error_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_ch.byte_kind == K_ERROR |->
      !result_ch.name_start && !result_ch.value_start && result_ch.line_event == LE_NONE)
    else $error("flags raised on an error byte");

  a_status_gate: assert property (@(posedge clk) disable iff (rst)
    out_valid && state < S_REASON |-> result_ch.status_code == '0)
    else $error("status code shown before status line done");

  a_block_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_ch.line_event == LE_BLOCK |-> state == S_BODY && !failed)
    else $error("header block end without entering body");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !byte_ch.ready |-> out_valid && !result_ch.ready)
    else $error("byte channel stalled with free result register");

endmodule
